[src/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rsi_pkg.sv]
package rsi_pkg;

  // field widths
  localparam int CH_W     = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ACCUM_W  = 31;
  localparam int RADIX_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int PROD_W   = ACCUM_W + RADIX_W;

  typedef logic [CH_W-1:0]     ch_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ACCUM_W-1:0]  accum_t;
  typedef logic [RADIX_W-1:0]  radix_t;

  // status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FORMAT   = 2'd1;
  localparam status_t ST_ILLEGAL  = 2'd2;
  localparam status_t ST_OVERFLOW = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT = 1'd1;

  localparam radix_t RADIX_RESET = 6'd10;
  localparam radix_t RADIX_MIN   = 6'd2;
  localparam radix_t RADIX_MAX   = 6'd36;
  localparam radix_t NO_DIGIT    = 6'd63;

  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(32'h7FFF_FFFF);

  // characters of interest
  localparam ch_t CH_NUL   = 8'h00;
  localparam ch_t CH_SPACE = 8'h20;
  localparam ch_t CH_PLUS  = 8'h2B;
  localparam ch_t CH_MINUS = 8'h2D;
  localparam ch_t CH_0     = 8'h30;
  localparam ch_t CH_9     = 8'h39;
  localparam ch_t CH_UA    = 8'h41;
  localparam ch_t CH_UZ    = 8'h5A;
  localparam ch_t CH_LA    = 8'h61;
  localparam ch_t CH_LZ    = 8'h7A;

  // clamp the configured radix into 2..36
  function automatic radix_t eff_radix(input radix_t r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // digit value of a character, NO_DIGIT when it is none
  function automatic radix_t digit_val(input ch_t c);
    ch_t t;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      return t[RADIX_W-1:0];
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
      return t[RADIX_W-1:0];
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
      return t[RADIX_W-1:0];
    end
    return NO_DIGIT;
  endfunction

endpackage

[src/radix_string_to_int32_top.sv]
// path: an accepted item waits in the input register; its result is written to the result register that drives out_*
// throughput: one character per cycle unless a result finds the output full, set by the
//   single multiply-add between the input register and the result register
// reset: synchronous, active low; clears the pipeline, the parse state and sets
//   radix to 10 and abort_on_error to 0
`include "assert_macros.svh"

module radix_string_to_int32_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rsi_pkg::ch_t                       in_ch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rsi_pkg::value_t                    out_result_value,
  output rsi_pkg::status_t                   out_status,
  output logic                               out_fatal,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rsi_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD    = 2'd0,
    PH_SIGN    = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // configuration
  radix_t radix_r;
  logic   abort_r;

  // input register
  logic s1_valid_r;
  ch_t  s1_ch_r;

  // parse state
  phase_t phase_r, phase_nxt;
  logic   negative_r, negative_nxt;
  accum_t accum_r, accum_nxt;

  // result register
  logic    out_valid_r;
  value_t  out_value_r, value_nxt;
  status_t out_status_r, status_nxt;
  logic    out_fatal_r, fatal_nxt;

  logic              emit;
  logic              out_free;
  logic              s1_adv;
  radix_t            rad;
  radix_t            dig;
  logic              dig_ok;
  logic [PROD_W-1:0] mag_nxt;
  logic              mag_ovf;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      abort_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIX: radix_r <= cfg_data[RADIX_W-1:0];
        CFG_ABORT: abort_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // digit decode and multiply-add
  assign rad     = eff_radix(radix_r);
  assign dig     = digit_val(s1_ch_r);
  assign dig_ok  = (dig != NO_DIGIT) && (dig < rad);
  assign mag_nxt = PROD_W'(accum_r) * PROD_W'(rad) + PROD_W'(dig);
  assign mag_ovf = mag_nxt > MAG_LIMIT;

  // parse step for the item in the input register
  always_comb begin
    phase_nxt    = phase_r;
    negative_nxt = negative_r;
    accum_nxt    = accum_r;
    emit         = 1'b0;
    value_nxt    = '0;
    status_nxt   = ST_OK;
    fatal_nxt    = 1'b0;
    case (phase_r)
      PH_LEAD, PH_SIGN, PH_DIGITS: begin
        if (phase_r == PH_LEAD && s1_ch_r == CH_SPACE) begin
          // skip leading space
        end else if (phase_r == PH_LEAD && s1_ch_r == CH_MINUS) begin
          negative_nxt = 1'b1;
          phase_nxt    = PH_SIGN;
        end else if (phase_r == PH_LEAD && s1_ch_r == CH_PLUS) begin
          phase_nxt = PH_SIGN;
        end else if (s1_ch_r == CH_NUL) begin
          emit         = 1'b1;
          negative_nxt = 1'b0;
          accum_nxt    = '0;
          phase_nxt    = PH_LEAD;
          if (phase_r == PH_DIGITS) begin
            value_nxt = negative_r ? (VALUE_W'(0) - VALUE_W'(accum_r)) : VALUE_W'(accum_r);
          end else begin
            status_nxt = ST_FORMAT;
            fatal_nxt  = abort_r;
          end
        end else if (!dig_ok || mag_ovf) begin
          emit         = 1'b1;
          status_nxt   = dig_ok ? ST_OVERFLOW : ST_ILLEGAL;
          fatal_nxt    = abort_r;
          negative_nxt = 1'b0;
          accum_nxt    = '0;
          phase_nxt    = PH_DISCARD;
        end else begin
          accum_nxt = mag_nxt[ACCUM_W-1:0];
          phase_nxt = PH_DIGITS;
        end
      end
      default: begin
        // discard up to the terminator
        if (s1_ch_r == CH_NUL) begin
          negative_nxt = 1'b0;
          accum_nxt    = '0;
          phase_nxt    = PH_LEAD;
        end
      end
    endcase
  end

  // handshake: the input register moves on unless its result finds the output full
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_ch_r <= in_ch;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      negative_r <= 1'b0;
      accum_r    <= '0;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      negative_r <= negative_nxt;
      accum_r    <= accum_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && emit) begin
      out_value_r  <= value_nxt;
      out_status_r <= status_nxt;
      out_fatal_r  <= fatal_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_fatal        = out_fatal_r;

  // checks
  `ASSERT_CLK(a_ok_not_fatal, clk, rst_n, (out_valid_r && out_status_r == ST_OK) |-> !out_fatal_r, "fatal set on ok result")
  `ASSERT_CLK(a_err_zero, clk, rst_n, (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0), "error result carries a value")
  `ASSERT_CLK(a_lead_clear, clk, rst_n, (phase_r == PH_LEAD) |-> (accum_r == '0 && !negative_r), "number not cleared in leading phase")
  `ASSERT_CLK(a_empty_ready, clk, rst_n, !s1_valid_r |-> in_ready, "empty input register refuses an item")

endmodule
